// ===== src/km2d_pkg.sv =====
// Shared types and constants for the 2D k-means iteration unit.
`default_nettype none
package km2d_pkg;
    localparam int FRAC_BITS = 8;

    localparam logic [1:0] CMD_LOAD_POINT = 2'd0;
    localparam logic [1:0] CMD_LOAD_CENT  = 2'd1;
    localparam logic [1:0] CMD_RUN        = 2'd2;

    localparam logic REG_NUM_CLUSTERS = 1'b0;
    localparam logic REG_NUM_POINTS   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST_X,
        ST_DIST_Y,
        ST_CMP,
        ST_EMIT_ASSIGN,
        ST_ACC,
        ST_DIV_X_START,
        ST_DIV_X,
        ST_DIV_Y_START,
        ST_DIV_Y,
        ST_EMIT_CENT
    } km_state_t;

    // Request from the sequencer into the shared divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;
endpackage
`default_nettype wire

// ===== src/kmeans_2d_iteration_unit.sv =====
// Top level of the 2D k-means (Lloyd) iteration unit.
`default_nettype none
// Channel  | Direction | Handshake      | Beat carries
// in       | input     | valid / ready  | command, slot, coord_x, coord_y
// out      | output    | out_valid/rdy  | kind, item_index, cluster, mean_x, mean_y, last
// cfg      | input     | APB write/read | num_clusters (0x0), num_points (0x4)
//
// The assignment pass of a run walks x term, y term and compare for each point
// and centroid pair through one shared multiplier, then emits one beat per point.
// Each cluster then accumulates over all points, starts the divider and emits
// its centroid; a cluster with members also runs its x and y divisions in the
// shared serial divider. Reset clears control and registers only; point and
// centroid stores are undefined until loaded. The sequencer holds while the
// output beat stalls.
module kmeans_2d_iteration_unit #(
    parameter int MAX_POINTS   = 32,
    parameter int MAX_CLUSTERS = 8,
    parameter int COORD_BITS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  slot,
    input  wire logic [15:0] coord_x,
    input  wire logic [15:0] coord_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [4:0]       item_index,
    output logic [2:0]       cluster,
    output logic [23:0]      mean_x,
    output logic [23:0]      mean_y,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CB    = COORD_BITS + km2d_pkg::FRAC_BITS;  // centroid width
    localparam int PIDX  = $clog2(MAX_POINTS);
    localparam int CIDX  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int PCNT  = $clog2(MAX_POINTS + 1);
    localparam int CCNT  = $clog2(MAX_CLUSTERS + 1);
    localparam int DIST  = 2 * CB + 1;
    localparam int SUMB  = COORD_BITS + PCNT;
    localparam int NUMB  = SUMB + km2d_pkg::FRAC_BITS;

    // Register file
    logic [3:0] num_clusters_reg;
    logic [5:0] num_points_reg;
    logic       wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg <= 4'd3;
            num_points_reg   <= 6'd10;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == km2d_pkg::REG_NUM_CLUSTERS)
                num_clusters_reg <= pwdata[3:0];
            else
                num_points_reg <= pwdata[5:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == km2d_pkg::REG_NUM_CLUSTERS)
            prdata[3:0] = num_clusters_reg;
        else
            prdata[5:0] = num_points_reg;
    end

    // Stores
    logic [COORD_BITS-1:0] pt_x_mem [MAX_POINTS];
    logic [COORD_BITS-1:0] pt_y_mem [MAX_POINTS];
    logic [CIDX-1:0]       label_mem [MAX_POINTS];
    logic [CB-1:0]         cen_x_mem [MAX_CLUSTERS];
    logic [CB-1:0]         cen_y_mem [MAX_CLUSTERS];

    km2d_pkg::km_state_t state_reg, state_next;
    logic [PCNT-1:0] p_reg, p_next;
    logic [CCNT-1:0] c_reg, c_next;
    logic [PCNT-1:0] np_reg, np_next;
    logic [CCNT-1:0] nc_reg, nc_next;
    logic [DIST-1:0] acc_reg, acc_next;
    logic [DIST-1:0] best_reg, best_next;
    logic [CIDX-1:0] best_c_reg, best_c_next;
    logic [SUMB-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [PCNT-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg;

    logic            accept, do_load_pt, do_load_cen;
    logic            emit;
    logic [PIDX-1:0] p_idx;
    logic [CIDX-1:0] c_idx;
    logic [CB-1:0]   pt_q, cen_q, diff;
    logic [2*CB-1:0] sq;
    km2d_pkg::div_ctrl_t div_ctrl;
    logic            div_busy;
    logic [NUMB-1:0] div_num, div_quot;
    logic            wr_cx, wr_cy;

    assign accept  = valid && ready;
    assign p_idx   = p_reg[PIDX-1:0];
    assign c_idx   = c_reg[CIDX-1:0];
    assign do_load_pt  = accept && command == km2d_pkg::CMD_LOAD_POINT
                         && {1'b0, slot} < 6'(MAX_POINTS);
    assign do_load_cen = accept && command == km2d_pkg::CMD_LOAD_CENT
                         && {1'b0, slot} < 6'(MAX_CLUSTERS);

    always_ff @(posedge clk)
    begin
        if (do_load_pt)
        begin
            pt_x_mem[PIDX'(slot)] <= COORD_BITS'(coord_x);
            pt_y_mem[PIDX'(slot)] <= COORD_BITS'(coord_y);
        end
        if (state_reg == km2d_pkg::ST_EMIT_ASSIGN && emit)
            label_mem[p_idx] <= best_c_reg;
        if (do_load_cen)
        begin
            cen_x_mem[CIDX'(slot)] <= {COORD_BITS'(coord_x),
                                       km2d_pkg::FRAC_BITS'(0)};
            cen_y_mem[CIDX'(slot)] <= {COORD_BITS'(coord_y),
                                       km2d_pkg::FRAC_BITS'(0)};
        end
        else if (wr_cx)
            cen_x_mem[c_idx] <= div_quot[CB-1:0];
        else if (wr_cy)
            cen_y_mem[c_idx] <= div_quot[CB-1:0];
    end

    // Shared squarer: one axis term per cycle
    always_comb
    begin
        if (state_reg == km2d_pkg::ST_DIST_Y)
        begin
            pt_q  = {pt_y_mem[p_idx], km2d_pkg::FRAC_BITS'(0)};
            cen_q = cen_y_mem[c_idx];
        end
        else
        begin
            pt_q  = {pt_x_mem[p_idx], km2d_pkg::FRAC_BITS'(0)};
            cen_q = cen_x_mem[c_idx];
        end
        diff = (pt_q >= cen_q) ? pt_q - cen_q : cen_q - pt_q;
    end

    logic [2*CB-1:0] sq_reg;
    always_ff @(posedge clk)
    begin
        sq_reg <= diff * diff;
    end
    assign sq = sq_reg;

    // Shared divider
    assign div_num = (state_reg == km2d_pkg::ST_DIV_Y_START
                      || state_reg == km2d_pkg::ST_DIV_Y)
                     ? {sy_reg, km2d_pkg::FRAC_BITS'(0)}
                     : {sx_reg, km2d_pkg::FRAC_BITS'(0)};
    assign div_ctrl.start = state_reg == km2d_pkg::ST_DIV_X_START
                            || state_reg == km2d_pkg::ST_DIV_Y_START;

    km2d_divider #(.NUM_BITS(NUMB), .DEN_BITS(PCNT)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (div_num),
        .denom (cnt_reg),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Store the finished quotient straight into the centroid entry
    assign wr_cx = state_reg == km2d_pkg::ST_DIV_X && !div_busy && cnt_reg != '0;
    assign wr_cy = state_reg == km2d_pkg::ST_DIV_Y && !div_busy && cnt_reg != '0;

    assign emit = !out_valid_reg || out_ready;

    // Next state. Distance walk: DIST_X issues x term, DIST_Y adds x and issues y,
    // CMP adds y and compares.
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        c_next      = c_reg;
        np_next     = np_reg;
        nc_next     = nc_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        best_c_next = best_c_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            km2d_pkg::ST_IDLE:
            begin
                if (accept && command == km2d_pkg::CMD_RUN)
                begin
                    if (num_clusters_reg == 4'd0)
                        nc_next = CCNT'(1);
                    else if (num_clusters_reg > 4'(MAX_CLUSTERS))
                        nc_next = CCNT'(MAX_CLUSTERS);
                    else
                        nc_next = CCNT'(num_clusters_reg);
                    if (num_points_reg == 6'd0)
                        np_next = PCNT'(1);
                    else if (num_points_reg > 6'(MAX_POINTS))
                        np_next = PCNT'(MAX_POINTS);
                    else
                        np_next = PCNT'(num_points_reg);
                    p_next = '0;
                    c_next = '0;
                    state_next = km2d_pkg::ST_DIST_X;
                end
            end
            km2d_pkg::ST_DIST_X:
                state_next = km2d_pkg::ST_DIST_Y;
            km2d_pkg::ST_DIST_Y:
            begin
                acc_next   = DIST'(sq);
                state_next = km2d_pkg::ST_CMP;
            end
            km2d_pkg::ST_CMP:
            begin
                acc_next = acc_reg + DIST'(sq);
                if (c_reg == '0 || acc_next < best_reg)
                begin
                    best_next   = acc_next;
                    best_c_next = c_idx;
                end
                if (c_reg + 1'b1 == nc_reg)
                    state_next = km2d_pkg::ST_EMIT_ASSIGN;
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = km2d_pkg::ST_DIST_X;
                end
            end
            km2d_pkg::ST_EMIT_ASSIGN:
            begin
                if (emit)
                begin
                    c_next = '0;
                    if (p_reg + 1'b1 == np_reg)
                    begin
                        p_next     = '0;
                        sx_next    = '0;
                        sy_next    = '0;
                        cnt_next   = '0;
                        state_next = km2d_pkg::ST_ACC;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = km2d_pkg::ST_DIST_X;
                    end
                end
            end
            km2d_pkg::ST_ACC:
            begin
                if (label_mem[p_idx] == c_idx)
                begin
                    sx_next  = sx_reg + SUMB'(pt_x_mem[p_idx]);
                    sy_next  = sy_reg + SUMB'(pt_y_mem[p_idx]);
                    cnt_next = cnt_reg + 1'b1;
                end
                if (p_reg + 1'b1 == np_reg)
                    state_next = km2d_pkg::ST_DIV_X_START;
                else
                    p_next = p_reg + 1'b1;
            end
            km2d_pkg::ST_DIV_X_START:
                state_next = (cnt_reg == '0) ? km2d_pkg::ST_EMIT_CENT
                                             : km2d_pkg::ST_DIV_X;
            km2d_pkg::ST_DIV_X:
                if (!div_busy) state_next = km2d_pkg::ST_DIV_Y_START;
            km2d_pkg::ST_DIV_Y_START:
                state_next = km2d_pkg::ST_DIV_Y;
            km2d_pkg::ST_DIV_Y:
                if (!div_busy) state_next = km2d_pkg::ST_EMIT_CENT;
            km2d_pkg::ST_EMIT_CENT:
            begin
                if (emit)
                begin
                    p_next   = '0;
                    sx_next  = '0;
                    sy_next  = '0;
                    cnt_next = '0;
                    if (c_reg + 1'b1 == nc_reg)
                        state_next = km2d_pkg::ST_IDLE;
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = km2d_pkg::ST_ACC;
                    end
                end
            end
            default:
                state_next = km2d_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= km2d_pkg::ST_IDLE;
            p_reg     <= '0;
            c_reg     <= '0;
            np_reg    <= '0;
            nc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            c_reg     <= c_next;
            np_reg    <= np_next;
            nc_reg    <= nc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        best_reg   <= best_next;
        best_c_reg <= best_c_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        cnt_reg    <= cnt_next;
    end

    // Output register
    logic        kind_reg, last_reg;
    logic [4:0]  idx_reg;
    logic [2:0]  cl_reg;
    logic [23:0] mx_reg, my_reg;
    logic        load_a, load_c;
    assign load_a = state_reg == km2d_pkg::ST_EMIT_ASSIGN && emit;
    assign load_c = state_reg == km2d_pkg::ST_EMIT_CENT && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_a || load_c)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            kind_reg <= 1'b0;
            idx_reg  <= 5'(p_reg);
            cl_reg   <= 3'(best_c_reg);
            mx_reg   <= '0;
            my_reg   <= '0;
            last_reg <= 1'b0;
        end
        else if (load_c)
        begin
            kind_reg <= 1'b1;
            idx_reg  <= 5'(c_reg);
            cl_reg   <= '0;
            mx_reg   <= 24'(cen_x_mem[c_idx]);
            my_reg   <= 24'(cen_y_mem[c_idx]);
            last_reg <= (c_reg + 1'b1 == nc_reg);
        end
    end

    assign ready      = state_reg == km2d_pkg::ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign item_index = idx_reg;
    assign cluster    = cl_reg;
    assign mean_x     = mx_reg;
    assign mean_y     = my_reg;
    assign last       = last_reg;
endmodule
`default_nettype wire

// ===== src/km2d_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module km2d_divider #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 6
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire km2d_pkg::div_ctrl_t ctrl,
    input  wire logic [NUM_BITS-1:0] numer,
    input  wire logic [DEN_BITS-1:0] denom,
    output logic                     busy,
    output logic [NUM_BITS-1:0]      quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg, quot_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        trial     = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
        if (ctrl.start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
        end
        else if (cnt_reg != '0)
        begin
            // shift in next numerator bit; subtract when it fits
            if (trial >= {1'b0, denom})
            begin
                rem_next  = trial - {1'b0, denom};
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = (cnt_reg != '0) || ctrl.start;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// ===== dv/kmeans_2d_iteration_unit_tb.sv =====
// Self-checking testbench for the 2D k-means iteration unit.
`timescale 1ns / 1ps
module kmeans_2d_iteration_unit_tb;

    localparam int NPTS = 32;
    localparam int NCL  = 8;

    typedef struct packed {
        logic        kind;
        logic [4:0]  item_index;
        logic [2:0]  cluster;
        logic [23:0] mean_x;
        logic [23:0] mean_y;
        logic        last;
    } km_beat_t;

    // Lloyd predictor plus queue of expected result beats
    class kmeans_scoreboard;
        logic [15:0] px [NPTS];
        logic [15:0] py [NPTS];
        logic [2:0]  lbl [NPTS];
        logic [23:0] cx [NCL];
        logic [23:0] cy [NCL];
        int unsigned n_clusters;
        int unsigned n_points;
        km_beat_t    pending[$];
        int          errors;

        function new();
            n_clusters = 3;
            n_points = 10;
            errors = 0;
            for (int i = 0; i < NPTS; i++)
            begin
                px[i] = 0; py[i] = 0; lbl[i] = 0;
            end
            for (int i = 0; i < NCL; i++)
            begin
                cx[i] = 0; cy[i] = 0;
            end
        endfunction

        function logic [64:0] sq_dist(int p, int c);
            logic [31:0] dx, dy, ax, ay;
            ax = {8'd0, px[p], 8'd0};
            ay = {8'd0, py[p], 8'd0};
            dx = (ax >= 32'(cx[c])) ? ax - 32'(cx[c]) : 32'(cx[c]) - ax;
            dy = (ay >= 32'(cy[c])) ? ay - 32'(cy[c]) : 32'(cy[c]) - ay;
            return 65'(64'(dx) * 64'(dx)) + 65'(64'(dy) * 64'(dy));
        endfunction

        function void note_input(logic [1:0] cmd, logic [4:0] sl, logic [15:0] x,
                                 logic [15:0] y);
            int nc, np, best_c, cnt;
            logic [64:0] best, d;
            logic [47:0] sx, sy;
            km_beat_t b;
            if (cmd == km2d_pkg::CMD_LOAD_POINT)
            begin
                px[sl] = x; py[sl] = y;
                return;
            end
            if (cmd == km2d_pkg::CMD_LOAD_CENT)
            begin
                if (sl < NCL)
                begin
                    cx[sl] = {x, 8'd0}; cy[sl] = {y, 8'd0};
                end
                return;
            end
            if (cmd != km2d_pkg::CMD_RUN)
                return;
            nc = (n_clusters < 1) ? 1 : (n_clusters > NCL) ? NCL : int'(n_clusters);
            np = (n_points < 1) ? 1 : (n_points > NPTS) ? NPTS : int'(n_points);
            for (int p = 0; p < np; p++)
            begin
                best = sq_dist(p, 0);
                best_c = 0;
                for (int c = 1; c < nc; c++)
                begin
                    d = sq_dist(p, c);
                    if (d < best)
                    begin
                        best = d; best_c = c;
                    end
                end
                lbl[p] = 3'(best_c);
                b = '0;
                b.item_index = 5'(p);
                b.cluster = 3'(best_c);
                pending.push_back(b);
            end
            for (int c = 0; c < nc; c++)
            begin
                sx = 0; sy = 0; cnt = 0;
                for (int p = 0; p < np; p++)
                    if (int'(lbl[p]) == c)
                    begin
                        sx += 48'(px[p]); sy += 48'(py[p]); cnt++;
                    end
                if (cnt != 0)
                begin
                    cx[c] = 24'((sx << 8) / 48'(cnt));
                    cy[c] = 24'((sy << 8) / 48'(cnt));
                end
                b = '0;
                b.kind = 1'b1;
                b.item_index = 5'(c);
                b.mean_x = cx[c];
                b.mean_y = cy[c];
                b.last = (c + 1 == nc);
                pending.push_back(b);
            end
        endfunction

        function void report(string fld, longint unsigned e, longint unsigned a);
            $display("%0t: mismatch on %s expected %0d actual %0d", $time, fld, e, a);
            errors++;
        endfunction

        function void check_result(km_beat_t got);
            km_beat_t exp_b;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
                return;
            end
            exp_b = pending.pop_front();
            if (got.kind != exp_b.kind)
                report("kind", exp_b.kind, got.kind);
            if (got.item_index != exp_b.item_index)
                report("item_index", exp_b.item_index, got.item_index);
            if (got.cluster != exp_b.cluster)
                report("cluster", exp_b.cluster, got.cluster);
            if (got.mean_x != exp_b.mean_x)
                report("mean_x", exp_b.mean_x, got.mean_x);
            if (got.mean_y != exp_b.mean_y)
                report("mean_y", exp_b.mean_y, got.mean_y);
            if (got.last != exp_b.last)
                report("last", exp_b.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic ready;
    logic [1:0] command = '0;
    logic [4:0] slot = '0;
    logic [15:0] coord_x = '0;
    logic [15:0] coord_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic kind, last;
    logic [4:0] item_index;
    logic [2:0] cluster;
    logic [23:0] mean_x, mean_y;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kmeans_2d_iteration_unit DUT (.*);

    kmeans_scoreboard sb;
    bit hold_off = 0;
    int sent_count = 0;
    bit point_loaded [NPTS];
    bit cent_loaded [NCL];

    always #5 clk = ~clk;

    // Short gaps mostly, an occasional long one, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat, hold it stable until accepted
    task automatic send_beat(logic [1:0] cmd, logic [4:0] sl, logic [15:0] x,
                             logic [15:0] y);
        int g;
        command <= cmd; slot <= sl; coord_x <= x; coord_y <= y;
        valid <= 1'b1;
        do @(posedge clk); while (!ready);
        sb.note_input(cmd, sl, x, y);
        sent_count++;
        if (cmd == km2d_pkg::CMD_LOAD_POINT) point_loaded[sl] = 1;
        if (cmd == km2d_pkg::CMD_LOAD_CENT && sl < NCL) cent_loaded[sl] = 1;
        @(negedge clk);
        g = gap_len();
        if (g != 0)
        begin
            valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic idle_sender();
        valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for drain plus the tail of any in-flight work, then write a register
    task automatic write_reg(logic reg_idx, logic [31:0] value);
        idle_sender();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready)
        begin
            if (reg_idx == km2d_pkg::REG_NUM_CLUSTERS) sb.n_clusters = 32'(value[3:0]);
            else sb.n_points = 32'(value[5:0]);
        end
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Load everything a run with these sizes will read, then run it
    task automatic load_and_run(int nc, int np, bit reload);
        int ec, ep;
        ec = (nc < 1) ? 1 : (nc > NCL) ? NCL : nc;
        ep = (np < 1) ? 1 : (np > NPTS) ? NPTS : np;
        for (int i = 0; i < ep; i++)
            if (reload || !point_loaded[i])
                send_beat(km2d_pkg::CMD_LOAD_POINT, 5'(i), rnd_coord(), rnd_coord());
        for (int i = 0; i < ec; i++)
            if (reload || !cent_loaded[i])
                send_beat(km2d_pkg::CMD_LOAD_CENT, 5'(i), rnd_coord(), rnd_coord());
        send_beat(km2d_pkg::CMD_RUN, 5'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g != 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Sample result beats on the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({kind, item_index, cluster, mean_x, mean_y, last});

    initial
    begin
        int nc, np;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset sizes, extremes, ties, ignored loads and unknown command
        load_and_run(3, 10, 1);
        send_beat(km2d_pkg::CMD_LOAD_CENT, 5'd31, 16'hFFFF, 16'hFFFF);
        send_beat(2'd3, 5'd31, 16'hFFFF, 16'hFFFF);
        send_beat(km2d_pkg::CMD_LOAD_CENT, 5'd0, 16'd0, 16'd0);
        send_beat(km2d_pkg::CMD_LOAD_CENT, 5'd1, 16'd0, 16'd0);
        send_beat(km2d_pkg::CMD_LOAD_CENT, 5'd2, 16'hFFFF, 16'hFFFF);
        send_beat(km2d_pkg::CMD_RUN, 5'd0, 16'd0, 16'd0);
        write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'd8);
        write_reg(km2d_pkg::REG_NUM_POINTS, 32'd32);
        load_and_run(8, 32, 1);
        write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'd0);
        write_reg(km2d_pkg::REG_NUM_POINTS, 32'd0);
        send_beat(km2d_pkg::CMD_RUN, 5'd0, 16'd0, 16'd0);
        write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'd15);
        write_reg(km2d_pkg::REG_NUM_POINTS, 32'd63);
        send_beat(km2d_pkg::CMD_RUN, 5'd0, 16'd0, 16'd0);
        write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'd1);
        write_reg(km2d_pkg::REG_NUM_POINTS, 32'd1);
        load_and_run(1, 1, 1);

        // Pressure: stall the receiver while runs queue up behind it
        write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'd4);
        write_reg(km2d_pkg::REG_NUM_POINTS, 32'd12);
        hold_off = 1;
        repeat (4) send_beat(km2d_pkg::CMD_RUN, 5'd0, 16'd0, 16'd0);

        // Random phases of well-formed sequences plus noise
        while (sent_count < 320)
        begin
            nc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            np = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 16);
            write_reg(km2d_pkg::REG_NUM_CLUSTERS, 32'(nc));
            write_reg(km2d_pkg::REG_NUM_POINTS, 32'(np));
            repeat ($urandom_range(1, 3))
            begin
                load_and_run(nc, np, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    send_beat(2'($urandom_range(0, 3)) | 2'b01, 5'($urandom_range(8, 31)),
                              16'($urandom), 16'($urandom));
            end
        end
        idle_sender();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/km2d_pkg.sv
src/km2d_divider.sv
src/kmeans_2d_iteration_unit.sv
dv/kmeans_2d_iteration_unit_tb.sv
